// File: hw/rtl/atm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_pkg
// Shared types, constants and the sine table of the tone modulator.
// ----------------------------------------------------------------------------
package atm_pkg;

	// sine table and sample path
	localparam int SINE_ENTRIES = 256;
	localparam int SINE_AW      = $clog2(SINE_ENTRIES);
	localparam int DECIMATION   = 2;
	localparam int DEC_W        = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam int MAX_OUT      = 64;
	localparam int CNT_W        = $clog2(MAX_OUT + 1);
	localparam logic [14:0] FULL_SCALE = 15'h7fff;

	// divide by 100 as multiply by ceil(2^29 / 100), exact below 2^22
	localparam logic [22:0] RECIP_100 = 23'd5368710;
	localparam int RECIP_SH = 29;

	// result queue
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
	localparam int OCC_W      = 3;

	// modem modes
	localparam logic [2:0] MODE_AFSK      = 3'd0;
	localparam logic [2:0] MODE_QPSK      = 3'd1;
	localparam logic [2:0] MODE_8PSK      = 3'd2;
	localparam logic [2:0] MODE_SCRAMBLED = 3'd3;
	localparam logic [2:0] MODE_BASEBAND  = 3'd4;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TPS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TPSYM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARK      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AMP       = 3'd5;

	// gray maps, phase jump in units of 90 and 45 degrees
	localparam logic [1:0] QPSK_MAP [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
	localparam logic [2:0] EPSK_MAP [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4};

	localparam logic [7:0] PHASE45_TOP = 8'd32;

	typedef struct packed {
		logic data_bit;
		logic stretch;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] tps;
		logic [31:0] tpsym;
		logic [30:0] mark;
		logic [30:0] space;
		logic [6:0]  amp;
	} cfg_t;

	typedef struct packed {
		logic       wr;
		logic [2:0] mode;
	} mode_wr_t;

	typedef enum logic {
		CMD_TICK,
		CMD_SYMBOL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       stretch;
		logic       dat;
		logic [7:0] jump;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic               emit;
		logic               fin;
		logic               baseband;
		logic               dat;
		logic [SINE_AW-1:0] addr;
	} req_t;

	typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

	// long division by shift and subtract, only run at elaboration
	function automatic longint unsigned long_div(longint unsigned num,
		longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = 0;
		rem = 0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter wave by taylor series in q30, mirrored to a full period
	function automatic sine_tab_t build_sine();
		sine_tab_t         tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   t;
		longint unsigned   q;
		longint unsigned   div;
		longint            s;
		int                j;
		int                k;
		for (j = 0; j < SINE_ENTRIES; j++) begin
			tab[8'(j)] = 16'sd0;
		end
		for (j = 0; j <= 64; j++) begin
			x  = (longint'(j) * 64'd3373259426) >> 7;
			x2 = (x * x) >> 30;
			t  = x;
			s  = longint'(x);
			for (k = 1; k <= 7; k++) begin
				div = longint'((2 * k) * (2 * k + 1));
				t   = long_div((t * x2) >> 30, div);
				if (k[0])
					s = s - longint'(t);
				else
					s = s + longint'(t);
			end
			if (s < 0)
				s = 0;
			q = (longint'(s) * 64'd32767 + 64'd536870912) >> 30;
			if (q > 64'd32767)
				q = 64'd32767;
			tab[8'(j)]       = $signed(16'(q));
			tab[8'(128 - j)] = $signed(16'(q));
			tab[8'(128 + j)] = -$signed(16'(q));
			tab[8'(256 - j)] = -$signed(16'(q));
		end
		tab[0]   = 16'sd0;
		tab[128] = 16'sd0;
		return tab;
	endfunction

	localparam sine_tab_t WAVE_ROM = build_sine();

endpackage
`default_nettype wire

// File: hw/rtl/atm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_front
// Takes input bits, gathers psk bits, scrambles and queues symbol commands.
// ----------------------------------------------------------------------------
module atm_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [2:0]        mode,
	input  atm_pkg::mode_wr_t mode_wr,
	input  wire               push,
	input  atm_pkg::in_item_t data,
	output logic              full,
	input  wire               cmd_pop,
	output logic              cmd_valid,
	output atm_pkg::cmd_t     cmd
);
	import atm_pkg::*;

	logic [1:0]  bc_q, bc_nx;
	logic [1:0]  held_q, held_nx;
	logic [16:0] scr_q, scr_nx;
	logic        accept;
	logic        dat;
	logic        scr_bit;
	logic        cmd_ok;
	cmd_t        cmd_nx;

	cmd_t        queue_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        q_push;
	logic        q_pop;

	assign full   = (cnt_q == 2'd2);
	assign accept = push && !full;
	assign dat    = data.stretch ? 1'b0 : data.data_bit;
	assign scr_bit = dat ^ scr_q[16] ^ scr_q[11];

	always_comb begin
		bc_nx   = bc_q;
		held_nx = held_q;
		scr_nx  = scr_q;
		cmd_ok  = 1'b0;
		cmd_nx.kind    = CMD_SYMBOL;
		cmd_nx.stretch = data.stretch;
		cmd_nx.dat     = dat;
		cmd_nx.jump    = 8'd0;
		unique case (mode) inside
			MODE_QPSK: begin
				bc_nx = bc_q + 2'd1;
				if (!bc_q[0]) begin
					held_nx     = {1'b0, dat};
					cmd_nx.kind = CMD_TICK;
					cmd_ok      = data.stretch;
				end else begin
					cmd_nx.jump = {QPSK_MAP[{held_q[0], dat}], 6'd0};
					cmd_ok      = 1'b1;
				end
			end
			MODE_8PSK: begin
				if (bc_q < 2'd2) begin
					held_nx     = {held_q[0], dat};
					bc_nx       = bc_q + 2'd1;
					cmd_nx.kind = CMD_TICK;
					cmd_ok      = data.stretch;
				end else begin
					cmd_nx.jump = {EPSK_MAP[{held_q, dat}], 5'd0};
					held_nx     = 2'd0;
					bc_nx       = 2'd0;
					cmd_ok      = 1'b1;
				end
			end
			MODE_SCRAMBLED: begin
				scr_nx     = {scr_q[15:0], scr_bit};
				cmd_nx.dat = scr_bit;
				cmd_ok     = 1'b1;
			end
			MODE_AFSK, MODE_BASEBAND: begin
				cmd_ok = 1'b1;
			end
			default: begin
				// unused mode codes drop the bit
				cmd_ok = 1'b0;
			end
		endcase
	end

	assign q_push    = accept && cmd_ok;
	assign q_pop     = cmd_pop && (cnt_q != 2'd0);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = queue_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q   <= '0;
			held_q <= '0;
			scr_q  <= '0;
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (mode_wr.wr) begin
				bc_q   <= '0;
				held_q <= '0;
				scr_q  <= '0;
			end else if (accept) begin
				bc_q   <= bc_nx;
				held_q <= held_nx;
				scr_q  <= scr_nx;
			end
			if (q_push)
				wr_q <= !wr_q;
			if (q_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, q_push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (q_push)
			queue_q[wr_q] <= cmd_nx;
	end

endmodule
`default_nettype wire

// File: hw/rtl/atm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_seq
// Symbol sequencer: phase/tick accumulators; if issue_ok, one request a cycle.
// ----------------------------------------------------------------------------
module atm_seq (
	input  wire               clk,
	input  wire               arst_n,
	input  atm_pkg::cfg_t     cfg,
	input  atm_pkg::mode_wr_t mode_wr,
	input  wire               cmd_valid,
	input  atm_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	input  wire               issue_ok,
	output atm_pkg::req_t     req
);
	import atm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_LOOP,
		ST_FINISH
	} state_t;

	localparam logic signed [34:0] ACC_MAX = 35'sh1_FFFF_FFFF;
	localparam logic signed [34:0] ACC_MIN = 35'sh6_0000_0000;

	state_t             state_q;
	cmd_t               cmd_q;
	logic signed [33:0] tick_q;
	logic [31:0]        phase_q;
	logic [DEC_W-1:0]   dec_q;
	logic [CNT_W-1:0]   n_q;
	req_t               req_q;

	logic [30:0]        step;
	logic [31:0]        phase_nx;
	logic               baseband;
	logic [DEC_W:0]     dec_inc;
	logic               dec_hit;
	logic               emit;
	logic signed [33:0] tick_add;
	logic signed [33:0] tick_sub;
	logic [CNT_W-1:0]   n_nx;
	logic               fin;

	function automatic logic signed [33:0] sat34(input logic signed [34:0] v);
		if (v > ACC_MAX)
			return ACC_MAX[33:0];
		if (v < ACC_MIN)
			return ACC_MIN[33:0];
		return v[33:0];
	endfunction

	always_comb begin
		step     = ((cfg.mode == MODE_AFSK) && cmd_q.dat) ? cfg.space : cfg.mark;
		phase_nx = phase_q + {1'b0, step};
		baseband = (cfg.mode == MODE_SCRAMBLED) || (cfg.mode == MODE_BASEBAND);
		dec_inc  = {1'b0, dec_q} + {{DEC_W{1'b0}}, 1'b1};
		dec_hit  = (dec_inc >= (DEC_W + 1)'(DECIMATION));
		emit     = baseband ? dec_hit : 1'b1;
		tick_add = sat34({tick_q[33], tick_q} + $signed({3'b000, cfg.tps}));
		tick_sub = sat34({tick_q[33], tick_q} - $signed({3'b000, cfg.tpsym}));
		n_nx     = n_q + {{(CNT_W-1){1'b0}}, emit};
		fin      = (tick_add >= $signed({2'b00, cfg.tpsym})) ||
		           (n_nx >= CNT_W'(MAX_OUT));
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign req     = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '0;
			tick_q  <= '0;
			phase_q <= '0;
			dec_q   <= '0;
			n_q     <= '0;
			req_q   <= '0;
		end else begin
			if (mode_wr.wr) begin
				tick_q      <= '0;
				dec_q       <= '0;
				phase_q     <= (mode_wr.mode == MODE_QPSK) ? {PHASE45_TOP, 24'd0} : 32'd0;
				req_q.valid <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						req_q.valid <= 1'b0;
						if (cmd_valid) begin
							cmd_q   <= cmd;
							state_q <= ST_START;
						end
					end
					ST_START: begin
						req_q.valid <= 1'b0;
						if (cmd_q.stretch)
							tick_q <= tick_sub;
						n_q <= '0;
						if (cmd_q.kind == CMD_SYMBOL) begin
							phase_q <= phase_q + {cmd_q.jump, 24'd0};
							state_q <= ST_LOOP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
					ST_LOOP: begin
						req_q.valid <= issue_ok;
						if (issue_ok) begin
							if (baseband)
								dec_q <= dec_hit ? '0 : dec_inc[DEC_W-1:0];
							else
								phase_q <= phase_nx;
							tick_q         <= tick_add;
							n_q            <= n_nx;
							req_q.emit     <= emit;
							req_q.fin      <= fin;
							req_q.baseband <= baseband;
							req_q.dat      <= cmd_q.dat;
							req_q.addr     <= phase_nx[31 -: SINE_AW];
							if (fin)
								state_q <= ST_FINISH;
						end
					end
					ST_FINISH: begin
						req_q.valid <= 1'b0;
						tick_q      <= tick_sub;
						state_q     <= ST_IDLE;
					end
					default: begin
						req_q.valid <= 1'b0;
						state_q     <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/atm_level.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_level
// Sample path: sine lookup or baseband level, scaling, clipping, last marking.
// ----------------------------------------------------------------------------
module atm_level (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [6:0]                     amp,
	input  atm_pkg::req_t                  req,
	output logic [atm_pkg::OCC_W-1:0]      occ,
	output logic                           push,
	output atm_pkg::out_item_t             push_item
);
	import atm_pkg::*;

	logic signed [15:0] rom_val;
	logic [14:0]        mag_c;
	logic               neg_c;

	logic        v_s1, e_s1, f_s1, n_s1;
	logic [14:0] mag_s1;
	logic        v_s2, e_s2, f_s2, n_s2;
	logic [21:0] prod_s2;
	logic        v_s3, e_s3, f_s3, n_s3;
	logic [15:0] quo_s3;

	logic [44:0]        scaled;
	logic [14:0]        clipped;
	logic signed [15:0] value;

	out_item_t pend_q;
	logic      pend_v_q;
	logic      pend_fin_q;

	always_comb begin
		rom_val = WAVE_ROM[req.addr];
		if (req.baseband) begin
			mag_c = FULL_SCALE;
			neg_c = !req.dat;
		end else begin
			mag_c = rom_val[15] ? 15'(-rom_val) : rom_val[14:0];
			neg_c = rom_val[15];
		end
		scaled  = {23'd0, prod_s2} * {22'd0, RECIP_100};
		clipped = (quo_s3 > {1'b0, FULL_SCALE}) ? FULL_SCALE : quo_s3[14:0];
		value   = n_s3 ? -$signed({1'b0, clipped}) : $signed({1'b0, clipped});
	end

	// pipeline, never stalls: room in the result queue is reserved at issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		e_s1    <= req.emit;
		f_s1    <= req.fin;
		n_s1    <= neg_c;
		mag_s1  <= mag_c;
		e_s2    <= e_s1;
		f_s2    <= f_s1;
		n_s2    <= n_s1;
		prod_s2 <= {7'd0, mag_s1} * {15'd0, amp};
		e_s3    <= e_s2;
		f_s3    <= f_s2;
		n_s3    <= n_s2;
		quo_s3  <= scaled[RECIP_SH +: 16];
	end

	// hold one sample back until it is known whether it closes the symbol
	always_comb begin
		push      = 1'b0;
		push_item = pend_q;
		if (pend_fin_q) begin
			push           = 1'b1;
			push_item.last = 1'b1;
		end else if (v_s3 && e_s3) begin
			push           = pend_v_q;
			push_item.last = 1'b0;
		end else if (v_s3 && f_s3) begin
			push           = pend_v_q;
			push_item.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q   <= 1'b0;
			pend_fin_q <= 1'b0;
			pend_q     <= '0;
		end else begin
			if (pend_fin_q) begin
				pend_v_q   <= 1'b0;
				pend_fin_q <= 1'b0;
			end else if (v_s3 && e_s3) begin
				pend_v_q      <= 1'b1;
				pend_fin_q    <= f_s3;
				pend_q.sample <= value;
				pend_q.last   <= 1'b0;
			end else if (v_s3 && f_s3) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	assign occ = OCC_W'($countones({req.valid & req.emit, v_s1 & e_s1, v_s2 & e_s2,
		v_s3 & e_s3, pend_v_q}));

endmodule
`default_nettype wire

// File: hw/rtl/atm_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_outq
// Result queue between the sample path and the consumer.
// ----------------------------------------------------------------------------
module atm_outq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  atm_pkg::out_item_t           push_item,
	input  wire                          pop,
	output logic                         empty,
	output atm_pkg::out_item_t           head,
	output logic [atm_pkg::OUTQ_CW-1:0]  count
);
	import atm_pkg::*;

	out_item_t          mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_q;
	logic [OUTQ_AW-1:0] rd_q;
	logic [OUTQ_CW-1:0] cnt_q;
	logic               do_pop;

	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign head   = mem_q[rd_q];
	assign count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + OUTQ_AW'(1);
			if (do_pop)
				rd_q <= rd_q + OUTQ_AW'(1);
			cnt_q <= cnt_q + OUTQ_CW'(push) - OUTQ_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

// File: hw/rtl/afsk_psk_tone_modulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afsk_psk_tone_modulator_unit
// Afsk, qpsk, 8psk, scrambled and baseband tone modulator, one audio channel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  data      in         push / full          data_bit, stretch
//  result    out        empty / pop          sample, last
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one sample per cycle in the loop state while results are drained; a symbol
// passes the sequencer states idle, start, loop and finish
// a psk item that only stores a bit is a tick command only with stretch
// the four-stage sample path and the eight-item result queue set the lag
// reset is asynchronous and clears the control registers, not the stored
// data; the sine table is constant logic, so there is no clearing pass
// ----------------------------------------------------------------------------
module afsk_psk_tone_modulator_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               push,
	output logic                              full,
	input  atm_pkg::in_item_t                 data,
	output logic                              empty,
	input  wire                               pop,
	output atm_pkg::out_item_t                result,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [atm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [31:0]                       cfg_data
);
	import atm_pkg::*;

	// configuration registers
	logic [2:0]  mode_q;
	logic [31:0] tps_q;
	logic [31:0] tpsym_q;
	logic [30:0] mark_q;
	logic [30:0] space_q;
	logic [6:0]  amp_q;

	logic        cfg_wr;
	cfg_t        cfg;
	mode_wr_t    mode_wr;

	// front to sequencer
	logic        cmd_valid;
	logic        cmd_pop;
	cmd_t        cmd;

	// sequencer to sample path
	req_t        req;
	logic        issue_ok;
	logic [OCC_W-1:0]   occ;
	logic [OUTQ_CW-1:0] oq_count;

	// sample path to result queue
	logic        lvl_push;
	out_item_t   lvl_item;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_AFSK;
			tps_q   <= 32'd97391;
			tpsym_q <= 32'd3579139;
			mark_q  <= 31'd116868891;
			space_q <= 31'd214259633;
			amp_q   <= 7'd50;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[2:0];
				REG_TPS:   tps_q   <= cfg_data;
				REG_TPSYM: tpsym_q <= cfg_data;
				REG_MARK:  mark_q  <= cfg_data[30:0];
				REG_SPACE: space_q <= cfg_data[30:0];
				REG_AMP:   amp_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// a mode write restarts the modulator state
	assign mode_wr.wr   = cfg_wr && (cfg_index == REG_MODE);
	assign mode_wr.mode = cfg_data[2:0];

	assign cfg.mode  = mode_q;
	assign cfg.tps   = tps_q;
	assign cfg.tpsym = tpsym_q;
	assign cfg.mark  = mark_q;
	assign cfg.space = space_q;
	assign cfg.amp   = amp_q;

	// front: classifies bits and queues symbol commands
	atm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.mode_wr   (mode_wr),
		.push      (push),
		.data      (data),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// a sample is issued only when its result has a reserved queue slot
	assign issue_ok = ({2'b00, occ} + {1'b0, oq_count}) < 5'(OUTQ_DEPTH);

	// back: walks the samples of each symbol
	atm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mode_wr   (mode_wr),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.issue_ok  (issue_ok),
		.req       (req)
	);

	// sine lookup, scaling, clipping, last flag
	atm_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.amp       (amp_q),
		.req       (req),
		.occ       (occ),
		.push      (lvl_push),
		.push_item (lvl_item)
	);

	// result queue, parts the sample path from the consumer
	atm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (lvl_push),
		.push_item (lvl_item),
		.pop       (pop),
		.empty     (empty),
		.head      (result),
		.count     (oq_count)
	);

endmodule
`default_nettype wire
